[rtl/ipld_pkg.sv]
// shared types, widths, codes and helpers of the indexed point list distance block
package ipld_pkg;

   localparam int IPLD_CAPACITY = 32;

   localparam int KIND_W   = 2;
   localparam int POS_W    = 5;
   localparam int COORD_W  = 16;
   localparam int MAG_W    = 16;
   localparam int SQ_W     = 2 * MAG_W;
   localparam int SQ_CNT_W = $clog2(MAG_W + 1);
   localparam int RAD_W    = SQ_W + 1;
   localparam int FRAC_W   = 8;
   localparam int ROOT_W   = 25;
   localparam int RT_CNT_W = $clog2(ROOT_W + 1);
   localparam int TOTAL_W  = 6;
   localparam int STATUS_W = 2;

   localparam int REQ_FIELDS_W = 2 * POS_W + 2 * COORD_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = ROOT_W + TOTAL_W + STATUS_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT   = 2'd0,
      KIND_REMOVE   = 2'd1,
      KIND_DISTANCE = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MOVE,
      ST_RD_FIRST,
      ST_RD_SECOND,
      ST_DIFF,
      ST_SQUARE,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } point_type;

   // magnitude of a - b, which always fits the coordinate width unsigned
   function automatic logic [MAG_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
      logic [COORD_W:0] d;
      logic [COORD_W:0] n;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      n = ~d + 1'b1;
      return d[COORD_W] ? n[MAG_W-1:0] : d[MAG_W-1:0];
   endfunction

endpackage

[rtl/indexed_point_list_distance_top.sv]
// indexed point list with distance query: control, point store and serial arithmetic
//
// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  tuser: kind; tdata: position, other_position, x, y
// rsp       out  rsp_tvalid/rsp_tready  tdata: distance, entry_total, status
//
// one word is taken at a time; ready is high only while the controller is idle
// an insert or remove moves n entries through the single write port of the point store,
//   one entry a cycle; n is count - position for insert and count - position - 1 for
//   remove
// distance steps through idle, decode, two store reads and a difference state, then the
//   serial squarers, the serial square root and a hand-over state;
//   rejected items go from decode straight to hand-over
// the result sits in an output register, so a new word is taken while it waits;
//   the next result holds in done until that register drains
// reset (synchronous) empties the list; point contents are not cleared
module indexed_point_list_distance_top
   import ipld_pkg::*;
#(
   parameter int CAPACITY = IPLD_CAPACITY
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [KIND_W-1:0]     req_tuser,   // kind
   input  logic [REQ_DATA_W-1:0] req_tdata,   // position, other_position, x_coord, y_coord
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // distance, entry_total, status
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   // request field offsets
   localparam int OFS_POS2 = POS_W;
   localparam int OFS_X    = 2 * POS_W;
   localparam int OFS_Y    = 2 * POS_W + COORD_W;

   state_type  state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          wr_pend_ff, wr_pend_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   status_type    status_ff, status_in;
   logic [ROOT_W-1:0] dist_ff, dist_in;
   point_type     first_ff, first_in;

   // latched request word
   kind_type          kind_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  pos2_ff;
   point_type         pt_ff;

   // output register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_load;

   // store port
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   point_type     mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   point_type     rd_data;

   // arithmetic units
   logic              sq_start;
   logic              sq_busy_x;
   logic              sq_busy_y;
   logic [SQ_W-1:0]   sq_x;
   logic [SQ_W-1:0]   sq_y;
   logic [MAG_W-1:0]  mag_x;
   logic [MAG_W-1:0]  mag_y;
   logic              rt_start;
   logic              rt_busy;
   logic [RAD_W-1:0]  rad;
   logic [ROOT_W-1:0] root;

   logic req_fire;
   logic ins;
   logic more;
   logic [CMPW-1:0] pos_c;
   logic [CMPW-1:0] pos2_c;
   logic [CMPW-1:0] cnt_c;
   logic [CMPW-1:0] idx_c;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign pos_c  = CMPW'(pos_ff);
   assign pos2_c = CMPW'(pos2_ff);
   assign cnt_c  = CMPW'(count_ff);
   assign idx_c  = CMPW'(idx_ff);

   // insert walks down from the count, remove walks up to it
   assign ins  = (kind_ff == KIND_INSERT);
   assign more = ins ? (idx_c > pos_c) : (idx_c < cnt_c);

   assign mag_x = abs_diff(rd_data.x, first_ff.x);
   assign mag_y = abs_diff(rd_data.y, first_ff.y);
   assign rad   = RAD_W'(sq_x) + RAD_W'(sq_y);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff  <= kind_type'(req_tuser);
         pos_ff   <= req_tdata[POS_W-1:0];
         pos2_ff  <= req_tdata[OFS_POS2 +: POS_W];
         pt_ff.x  <= req_tdata[OFS_X +: COORD_W];
         pt_ff.y  <= req_tdata[OFS_Y +: COORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      wr_addr_ff <= wr_addr_in;
      status_ff  <= status_in;
      dist_ff    <= dist_in;
      first_ff   <= first_in;
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      wr_pend_in = wr_pend_ff;
      wr_addr_in = wr_addr_ff;
      status_in  = status_ff;
      dist_in    = dist_ff;
      first_in   = first_ff;
      mem_we     = 1'b0;
      mem_waddr  = wr_addr_ff;
      mem_wdata  = rd_data;
      mem_re     = 1'b0;
      mem_raddr  = '0;
      sq_start   = 1'b0;
      rt_start   = 1'b0;
      rsp_load   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            dist_in    = '0;
            status_in  = STATUS_OK;
            wr_pend_in = 1'b0;
            state_in   = ST_DONE;
            unique case (kind_ff)
               KIND_INSERT: begin
                  // full list wins over a bad position
                  priority if (count_ff == CW'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                  end else if (pos_c > cnt_c) begin
                     status_in = STATUS_RANGE;
                  end else begin
                     idx_in   = count_ff;
                     state_in = ST_MOVE;
                  end
               end
               KIND_REMOVE: begin
                  if (pos_c >= cnt_c) begin
                     status_in = STATUS_RANGE;
                  end else begin
                     idx_in   = CW'(pos_ff) + CW'(1);
                     state_in = ST_MOVE;
                  end
               end
               KIND_DISTANCE: begin
                  if (pos_c >= cnt_c || pos2_c >= cnt_c) begin
                     status_in = STATUS_RANGE;
                  end else begin
                     state_in = ST_RD_FIRST;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         ST_MOVE: begin
            // write back the entry read last cycle, one slot over
            if (wr_pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wr_addr_ff;
               mem_wdata = rd_data;
            end
            if (more) begin
               mem_re     = 1'b1;
               wr_pend_in = 1'b1;
               if (ins) begin
                  mem_raddr  = AW'(idx_ff - CW'(1));
                  wr_addr_in = AW'(idx_ff);
                  idx_in     = idx_ff - CW'(1);
               end else begin
                  mem_raddr  = AW'(idx_ff);
                  wr_addr_in = AW'(idx_ff - CW'(1));
                  idx_in     = idx_ff + CW'(1);
               end
            end else if (wr_pend_ff) begin
               wr_pend_in = 1'b0;
            end else begin
               if (ins) begin
                  mem_we    = 1'b1;
                  mem_waddr = AW'(pos_ff);
                  mem_wdata = pt_ff;
                  count_in  = count_ff + CW'(1);
               end else begin
                  count_in  = count_ff - CW'(1);
               end
               state_in = ST_DONE;
            end
         end

         ST_RD_FIRST: begin
            mem_re    = 1'b1;
            mem_raddr = AW'(pos_ff);
            state_in  = ST_RD_SECOND;
         end

         ST_RD_SECOND: begin
            mem_re    = 1'b1;
            mem_raddr = AW'(pos2_ff);
            first_in  = rd_data;
            state_in  = ST_DIFF;
         end

         ST_DIFF: begin
            sq_start = 1'b1;
            state_in = ST_SQUARE;
         end

         ST_SQUARE: begin
            if (!sq_busy_x && !sq_busy_y) begin
               state_in = ST_ROOT_GO;
            end
         end

         ST_ROOT_GO: begin
            rt_start = 1'b1;
            state_in = ST_ROOT_WAIT;
         end

         ST_ROOT_WAIT: begin
            if (!rt_busy) begin
               dist_in  = root;
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            // hand over once the output register is free or draining
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= RSP_DATA_W'({status_ff, TOTAL_W'(count_ff), dist_ff});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   ipld_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (rd_data)
   );

   ipld_square u_square_x (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (mag_x),
      .busy    (sq_busy_x),
      .product (sq_x)
   );

   ipld_square u_square_y (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (mag_y),
      .busy    (sq_busy_y),
      .product (sq_y)
   );

   ipld_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (rt_start),
      .radicand (rad),
      .busy     (rt_busy),
      .root     (root)
   );

endmodule

[rtl/ipld_store.sv]
// point store: one write port, one read port with registered read data
module ipld_store
   import ipld_pkg::*;
#(
   parameter int CAPACITY = IPLD_CAPACITY,
   localparam int AW = $clog2(CAPACITY)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  point_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output point_type     rd_data
);

   point_type mem [CAPACITY];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ipld_square.sv]
// bit-serial squarer: one multiplier bit per cycle, shift and add
module ipld_square
   import ipld_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MAG_W-1:0] operand,
   output logic             busy,
   output logic [SQ_W-1:0]  product
);

   logic [SQ_W-1:0]     mcand_ff;
   logic [MAG_W-1:0]    mplier_ff;
   logic [SQ_W-1:0]     acc_ff;
   logic [SQ_CNT_W-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= SQ_CNT_W'(MAG_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff  <= SQ_W'(operand);
         mplier_ff <= operand;
         acc_ff    <= '0;
      end else if (cnt_ff != '0) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= {mcand_ff[SQ_W-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[MAG_W-1:1]};
      end
   end

   assign busy    = (cnt_ff != '0);
   assign product = acc_ff;

endmodule

[rtl/ipld_sqrt.sv]
// digit-by-digit square root, one root bit per cycle, radicand scaled by 2^(2*frac)
module ipld_sqrt
   import ipld_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              busy,
   output logic [ROOT_W-1:0] root
);

   localparam int V_W   = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;

   logic [V_W-1:0]      v_ff;
   logic [REM_W-1:0]    rem_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [RT_CNT_W-1:0] cnt_ff;

   logic [REM_W-1:0] rem_shift;
   logic [REM_W-1:0] trial;
   logic             take;

   assign rem_shift = {rem_ff[REM_W-3:0], v_ff[V_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign take      = (rem_shift >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= RT_CNT_W'(ROOT_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff    <= V_W'({radicand, {(2 * FRAC_W){1'b0}}});
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cnt_ff != '0) begin
         v_ff    <= {v_ff[V_W-3:0], 2'b00};
         rem_ff  <= take ? (rem_shift - trial) : rem_shift;
         root_ff <= {root_ff[ROOT_W-2:0], take};
      end
   end

   assign busy = (cnt_ff != '0);
   assign root = root_ff;

endmodule

[rtl/ipld_checker.sv]
// port-level checks of the point list block and their binding
module ipld_checker
   import ipld_pkg::*;
#(
   parameter int CAPACITY = IPLD_CAPACITY
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready
);

   localparam int OFS_TOTAL  = ROOT_W;
   localparam int OFS_STATUS = ROOT_W + TOTAL_W;

   logic [ROOT_W-1:0]   rsp_dist;
   logic [TOTAL_W-1:0]  rsp_total;
   logic [STATUS_W-1:0] rsp_status;

   assign rsp_dist   = rsp_tdata[ROOT_W-1:0];
   assign rsp_total  = rsp_tdata[OFS_TOTAL +: TOTAL_W];
   assign rsp_status = rsp_tdata[OFS_STATUS +: STATUS_W];

   // empty output after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // one word at a time
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while busy");

   // full only reported with a full list
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == STATUS_FULL |-> rsp_total == TOTAL_W'(CAPACITY))
      else $error("full status with list not full");

   // rejected items carry no distance
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status != STATUS_OK |-> rsp_dist == '0)
      else $error("distance on a rejected item");

endmodule

bind indexed_point_list_distance_top ipld_checker #(
   .CAPACITY (CAPACITY)
) u_ipld_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

[sim/ipld_response_checker.sv]
// response checker: follows the point list through accepted words and checks each response word
module ipld_response_checker
   import ipld_pkg::*;
#(
   parameter int CAPACITY = IPLD_CAPACITY
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [KIND_W-1:0]     req_tuser,   // kind
   input  logic [REQ_DATA_W-1:0] req_tdata,   // position, other_position, x_coord, y_coord
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // distance, entry_total, status
   output int                    mismatch_count,
   output int                    outstanding
);

   typedef struct {
      logic [ROOT_W-1:0]   distance;
      logic [TOTAL_W-1:0]  entry_total;
      logic [STATUS_W-1:0] status;
   } answer_type;

   answer_type                answers_due[$];
   logic signed [COORD_W-1:0] list_x [CAPACITY];
   logic signed [COORD_W-1:0] list_y [CAPACITY];
   int                        list_len = 0;
   int                        mismatches = 0;

   // floor of the square root, one result bit at a time from the top
   function automatic logic [ROOT_W-1:0] floor_root(input logic [63:0] radicand);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= radicand) root = trial;
      end
      return root[ROOT_W-1:0];
   endfunction

   // applies one request to the list copy and returns the response it should give
   function automatic answer_type apply_request(input logic [KIND_W-1:0] kind,
                                                input int pos,
                                                input int pos2,
                                                input logic signed [COORD_W-1:0] x,
                                                input logic signed [COORD_W-1:0] y);
      answer_type  ans;
      longint      dx;
      longint      dy;
      logic [63:0] sum;
      ans.distance = '0;
      ans.status   = STATUS_OK;
      case (kind)
         KIND_INSERT: begin
            // full list wins over a bad position
            if (list_len >= CAPACITY) ans.status = STATUS_FULL;
            else if (pos > list_len) ans.status = STATUS_RANGE;
            else begin
               for (int i = list_len; i > pos; i--) begin
                  list_x[i] = list_x[i-1];
                  list_y[i] = list_y[i-1];
               end
               list_x[pos] = x;
               list_y[pos] = y;
               list_len++;
            end
         end
         KIND_REMOVE: begin
            if (pos >= list_len) ans.status = STATUS_RANGE;
            else begin
               for (int i = pos; i + 1 < list_len; i++) begin
                  list_x[i] = list_x[i+1];
                  list_y[i] = list_y[i+1];
               end
               list_len--;
            end
         end
         KIND_DISTANCE: begin
            if (pos >= list_len || pos2 >= list_len) ans.status = STATUS_RANGE;
            else begin
               dx = longint'(list_x[pos2]) - longint'(list_x[pos]);
               dy = longint'(list_y[pos2]) - longint'(list_y[pos]);
               sum = 64'(dx * dx + dy * dy);
               ans.distance = floor_root(sum << FRAC_W * 2);
            end
         end
         default: ;  // unused kind leaves the list alone
      endcase
      ans.entry_total = TOTAL_W'(list_len);
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         list_len = 0;
         answers_due.delete();
      end else begin
         // a response word always belongs to an earlier request word
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               $error("response word with no request outstanding: tdata %h", rsp_tdata);
               mismatches++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_tdata[ROOT_W-1:0] !== want.distance) begin
                  $error("distance: expected %0d, got %0d", want.distance,
                         rsp_tdata[ROOT_W-1:0]);
                  mismatches++;
               end
               if (rsp_tdata[ROOT_W +: TOTAL_W] !== want.entry_total) begin
                  $error("entry_total: expected %0d, got %0d", want.entry_total,
                         rsp_tdata[ROOT_W +: TOTAL_W]);
                  mismatches++;
               end
               if (rsp_tdata[ROOT_W + TOTAL_W +: STATUS_W] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status,
                         rsp_tdata[ROOT_W + TOTAL_W +: STATUS_W]);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            answers_due.push_back(apply_request(req_tuser,
                                                int'(req_tdata[POS_W-1:0]),
                                                int'(req_tdata[POS_W +: POS_W]),
                                                req_tdata[2*POS_W +: COORD_W],
                                                req_tdata[2*POS_W + COORD_W +: COORD_W]));
         end
      end
      mismatch_count <= mismatches;
      outstanding    <= answers_due.size();
   end

endmodule

[sim/tb_indexed_point_list_distance_top.sv]
// testbench top: drives request words and response back-pressure, then gives the verdict
module tb_indexed_point_list_distance_top;
   import ipld_pkg::*;

   localparam int CAPACITY      = IPLD_CAPACITY;
   localparam int PHASE_WORDS   = 100;   // random words per phase
   localparam int PHASES        = 10;
   localparam int IDLE_PERCENT  = 11;
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int SETTLE_CYCLES = 100;   // well past the slowest distance word
   localparam int CYCLE_LIMIT   = 400000;

   // kind code the block does not define; it must answer ok and change nothing
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7fff;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [KIND_W-1:0]     req_tuser  = '0;   // kind
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // position, other_position, x_coord, y_coord
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // distance, entry_total, status

   int mismatch_count;
   int outstanding;

   // stimulus-side view of the list length, only used to keep most words well formed
   int list_len   = 0;
   int words_sent = 0;
   int rsp_words  = 0;
   int stall_left = 0;
   bit hold_done  = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   indexed_point_list_distance_top #(.CAPACITY(CAPACITY)) u_top (.*);

   ipld_response_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

   // coordinates: extremes often, otherwise any 16-bit value
   function automatic logic signed [COORD_W-1:0] pick_coord();
      case ($urandom_range(9))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return '0;
         3: return '1;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   // offer one request word, with random idle cycles ahead of it; entered and left at a
   // falling edge, so valid stays high across back-to-back words
   task automatic offer_word(input logic [KIND_W-1:0] kind,
                             input int pos,
                             input int pos2,
                             input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
      // no idling while words 400..599 go out
      while (!(words_sent >= 400 && words_sent < 600) && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         req_tuser  <= KIND_W'($urandom);
         req_tdata  <= REQ_DATA_W'({$urandom, $urandom});
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_DATA_W'({y, x, POS_W'(pos2), POS_W'(pos)});
      case (kind)
         KIND_INSERT: if (list_len < CAPACITY && pos <= list_len) list_len++;
         KIND_REMOVE: if (pos < list_len) list_len--;
         default: ;
      endcase
      // wait for the accepting edge
      do @(posedge clock); while (!req_tready);
      words_sent++;
      @(negedge clock);
   endtask

   // one random word; most positions are legal for the current list, some are noise
   task automatic random_word(input int insert_pct, input int remove_pct);
      int                roll;
      int                pos;
      int                pos2;
      logic [KIND_W-1:0] kind;
      roll = $urandom_range(99);
      pos2 = $urandom_range(31);
      if (roll < 3) kind = KIND_UNUSED;
      else if (roll < 3 + insert_pct) kind = KIND_INSERT;
      else if (roll < 3 + insert_pct + remove_pct) kind = KIND_REMOVE;
      else kind = KIND_DISTANCE;
      if (kind == KIND_INSERT) begin
         pos = $urandom_range(list_len > 31 ? 31 : list_len);
      end else begin
         pos = (list_len == 0) ? 0 : $urandom_range(list_len - 1);
         if (kind == KIND_DISTANCE) pos2 = (list_len == 0) ? 0 : $urandom_range(list_len - 1);
      end
      if (kind == KIND_UNUSED || $urandom_range(99) < 12) begin
         pos  = $urandom_range(31);
         pos2 = $urandom_range(31);
      end
      offer_word(kind, pos, pos2, pick_coord(), pick_coord());
   endtask

   // receiver: random stalls, one long hold-off after 150 words, quiet for words 600..799
   initial begin
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (!(rsp_words >= 600 && rsp_words < 800) &&
                      $urandom_range(99) < IDLE_PERCENT) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
         // long hold-off: the output register fills and the block stops taking words
         if (!hold_done && rsp_words >= 150) begin
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) rsp_words <= rsp_words + 1;
   end

   // give up if the run hangs
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_indexed_point_list_distance_top: FAIL");
      $finish;
   end

   initial begin
      int insert_pct;
      int remove_pct;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list: everything out of range, unused kind answers ok
      offer_word(KIND_DISTANCE, 0, 0, '0, '0);
      offer_word(KIND_REMOVE, 0, 0, '0, '0);
      offer_word(KIND_INSERT, 1, 0, '0, '0);
      offer_word(KIND_UNUSED, 31, 31, '1, '1);

      // opposite corners give the largest distance, both ways round, and zero to itself
      offer_word(KIND_INSERT, 0, 0, COORD_MIN, COORD_MIN);
      offer_word(KIND_INSERT, 1, 0, COORD_MAX, COORD_MAX);
      offer_word(KIND_DISTANCE, 0, 1, '0, '0);
      offer_word(KIND_DISTANCE, 1, 0, '0, '0);
      offer_word(KIND_DISTANCE, 1, 1, '0, '0);

      // insert at the front and in the middle, then one past the end
      offer_word(KIND_INSERT, 0, 0, '0, '0);
      offer_word(KIND_INSERT, 1, 0, -16'sd1, 16'sd1);
      offer_word(KIND_INSERT, 5, 0, 16'sh1234, 16'sh5678);
      offer_word(KIND_DISTANCE, 0, 4, '0, '0);
      offer_word(KIND_DISTANCE, 4, 0, '0, '0);
      offer_word(KIND_DISTANCE, 0, 3, '0, '0);
      offer_word(KIND_DISTANCE, 2, 1, '0, '0);

      // removes: past the end, middle, front, last
      offer_word(KIND_REMOVE, 4, 0, '0, '0);
      offer_word(KIND_REMOVE, 1, 0, '0, '0);
      offer_word(KIND_REMOVE, 0, 0, '0, '0);
      offer_word(KIND_REMOVE, 1, 0, '0, '0);
      offer_word(KIND_UNUSED, 0, 0, 16'sh5555, 16'shaaaa);
      offer_word(KIND_INSERT, 31, 31, 16'shaaaa, 16'sh5555);

      // fill to capacity with random points, then work the full list
      while (list_len < CAPACITY) begin
         offer_word(KIND_INSERT, $urandom_range(list_len), $urandom_range(31),
                    pick_coord(), pick_coord());
      end
      offer_word(KIND_INSERT, 31, 0, pick_coord(), pick_coord());
      offer_word(KIND_INSERT, 0, 0, pick_coord(), pick_coord());
      offer_word(KIND_DISTANCE, 31, 0, '0, '0);
      offer_word(KIND_DISTANCE, 0, 31, '0, '0);
      offer_word(KIND_REMOVE, 31, 0, '0, '0);
      offer_word(KIND_INSERT, 31, 0, pick_coord(), pick_coord());
      offer_word(KIND_REMOVE, 0, 0, '0, '0);

      // random phases that grow, shrink or churn the list
      repeat (PHASES) begin
         case ($urandom_range(2))
            0: begin
               insert_pct = 55;
               remove_pct = 15;
            end
            1: begin
               insert_pct = 15;
               remove_pct = 55;
            end
            default: begin
               insert_pct = 35;
               remove_pct = 30;
            end
         endcase
         repeat (PHASE_WORDS) random_word(insert_pct, remove_pct);
      end

      // drain: wait for every response, then a quiet stretch for stray words
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("tb_indexed_point_list_distance_top: PASS");
      end else begin
         $display("tb_indexed_point_list_distance_top: FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/ipld_pkg.sv
rtl/ipld_store.sv
rtl/ipld_square.sv
rtl/ipld_sqrt.sv
rtl/indexed_point_list_distance_top.sv
rtl/ipld_checker.sv
sim/ipld_response_checker.sv
sim/tb_indexed_point_list_distance_top.sv
